// ----- rtl/core/kli_pkg.sv -----
package kli_pkg;

  localparam int TimeW  = 16;
  localparam int ValW   = 16;
  localparam int VecW   = 64;
  localparam int FactW  = 17;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_RANGE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0] REG_COMPONENTS = 1'd0;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/kli_ram.sv -----
module kli_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/kli_div.sv -----
module kli_div
  import kli_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [15:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {17'd0, den};

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The factor is capped at one.
  assign rsp = '{done: done, quot: (quo > 32'd65536) ? 17'd65536 : quo[16:0]};

endmodule

// ----- rtl/core/keyframe_linear_interpolator_unit.sv -----
// Keyframe linear interpolator.
// Requests enter on the in channel (valid/ready) with a kind, times and four
// values; one response per request leaves on the out channel (valid/ready).
// Kinds: clear the table, append a key, sample at a time, count a range.
// The key table lives in two synchronous RAMs of MAX_KEYS entries each.
// A request is handled one at a time by a sequencer that walks the times RAM
// one entry per read-and-test state pair (registered read port).
// Clear and append go straight to the response; a range query walks the keys
// up to the end of the range; a sample walks the keys, fetches the neighbours,
// runs the bit-serial divider when the neighbours differ, blends the four
// components and then presents the response.
// The divider and the walk set the throughput.
// The response is held in an output register; a new request is taken only
// once that register is free, so a stalled receiver stalls the input.
// Reset empties the table (key count zero) and sets value_components to 1;
// the RAM contents are left undefined.
// value_components is written through the APB port at byte address 0.
module keyframe_linear_interpolator_unit
  import kli_pkg::*;
#(
  parameter int MAX_KEYS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [15:0]        time_req,
  input  logic [15:0]        time_end,
  input  logic signed [15:0] value_0,
  input  logic signed [15:0] value_1,
  input  logic signed [15:0] value_2,
  input  logic signed [15:0] value_3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [15:0] result_0,
  output logic signed [15:0] result_1,
  output logic signed [15:0] result_2,
  output logic signed [15:0] result_3,
  output logic [3:0]         before_index,
  output logic [3:0]         after_index,
  output logic [16:0]        blend_factor,
  output logic [4:0]         keys_in_range,
  output logic signed [11:0] range_total,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_RDB, S_RDA, S_LATCH, S_DIV, S_WAITDIV,
    S_MUL, S_BLEND, S_RWALK, S_OUT
  } state_t;

  state_t state;

  logic [2:0]  value_components;
  logic [CW-1:0] key_count;

  // Request registers.
  logic [1:0]  rkind;
  logic [15:0] rtreq;
  logic [15:0] rtend;
  logic        rphase;

  logic [CW-1:0] idx;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0]   t_rdata;
  logic [63:0]   v_rdata;
  logic [63:0]   v_wdata;

  logic [CW-1:0] bidx;
  logic [CW-1:0] aidx;
  logic [15:0]   tb;
  logic [15:0]   ta;
  logic [63:0]   vb;
  logic [63:0]   va;
  logic [16:0]   factor;
  logic [2:0]    nc;
  logic [1:0]    lane;
  logic signed [33:0] prod;
  logic [4:0]    cnt;
  logic signed [11:0] total;
  logic          cnt_phase;
  logic          div_start;

  div_req_t dreq;
  div_rsp_t drsp;

  // APB register.
  assign pready = 1'b1;
  assign prdata = (paddr == {REG_COMPONENTS, 1'b0}) ? {29'd0, value_components} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_components <= 3'd1;
    end else if (psel && penable && pwrite && paddr == {REG_COMPONENTS, 1'b0}) begin
      value_components <= pwdata[2:0];
    end
  end

  assign nc = (value_components == 3'd0) ? 3'd1 :
              (value_components > 3'd4) ? 3'd4 : value_components;

  assign v_wdata = {value_3, value_2, value_1, value_0};
  assign we      = in_valid && in_ready && kind == KIND_APPEND &&
                   key_count < CW'(MAX_KEYS);
  assign waddr   = key_count[AW-1:0];

  kli_ram #(.Width(TimeW), .Depth(MAX_KEYS)) u_times (
    .clk(clk), .we(we), .waddr(waddr), .wdata(time_req),
    .raddr(raddr), .rdata(t_rdata)
  );

  kli_ram #(.Width(VecW), .Depth(MAX_KEYS)) u_values (
    .clk(clk), .we(we), .waddr(waddr), .wdata(v_wdata),
    .raddr(raddr), .rdata(v_rdata)
  );

  kli_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Read address follows the walk index or the neighbour being fetched.
  always_comb begin
    case (state)
      S_RDB:   raddr = bidx[AW-1:0];
      S_RDA:   raddr = aidx[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  logic signed [15:0] a_sel;
  logic signed [15:0] b_sel;
  logic signed [16:0] diff;
  assign a_sel = vb[16*lane +: 16];
  assign b_sel = va[16*lane +: 16];
  assign diff  = 17'(b_sel) - 17'(a_sel);

  // Integer part of the first value, truncated toward zero.
  logic signed [15:0] ipart;
  assign ipart = $signed(v_rdata[15:0]);
  logic signed [11:0] ipart_t;
  assign ipart_t = 12'((17'(ipart) + ((ipart < 0) ? 17'sd255 : 17'sd0)) >>> 8);

  assign dreq = '{start: div_start, num: {rtreq - tb, 16'd0}, den: ta - tb};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      key_count <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_DIV) && (ta > tb) && (rtreq >= tb);
      if (state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            rkind <= kind; rtreq <= time_req; rtend <= time_end;
            status <= (kind == KIND_APPEND && key_count >= CW'(MAX_KEYS)) ? ST_FULL :
                      (kind == KIND_SAMPLE && key_count == '0) ? ST_EMPTY : ST_OK;
            result_0 <= '0; result_1 <= '0; result_2 <= '0; result_3 <= '0;
            before_index <= '0; after_index <= '0; blend_factor <= '0;
            keys_in_range <= '0; range_total <= '0;
            idx <= '0; rphase <= 1'b0; cnt <= '0; total <= '0;
            cnt_phase <= 1'b0;
            case (kind)
              KIND_CLEAR: begin
                key_count <= '0;
                state <= S_OUT;
              end
              KIND_APPEND: begin
                if (key_count < CW'(MAX_KEYS)) key_count <= key_count + 1'b1;
                state <= S_OUT;
              end
              KIND_SAMPLE: begin
                if (key_count == '0) begin
                  state <= S_OUT;
                end else if (time_req == 16'd0) begin
                  state <= S_RDB;
                  bidx <= '0; aidx <= '0;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                state <= (key_count == '0) ? S_OUT : S_RWALK;
              end
            endcase
          end
        end
        // Walk: rphase 0 issues the read, rphase 1 tests the data.
        S_WALK: begin
          if (!rphase) begin
            rphase <= 1'b1;
          end else begin
            rphase <= 1'b0;
            if (t_rdata < rtreq && idx + 1'b1 < key_count) begin
              idx <= idx + 1'b1;
            end else begin
              if (t_rdata < rtreq) begin
                aidx <= key_count - 1'b1;
                bidx <= key_count - 1'b1;
              end else begin
                aidx <= idx;
                bidx <= (idx == '0) ? '0 : idx - 1'b1;
              end
              state <= S_RDB;
            end
          end
        end
        S_RDB: begin
          state <= S_RDA;
        end
        S_RDA: begin
          tb <= t_rdata; vb <= v_rdata;
          state <= S_LATCH;
        end
        S_LATCH: begin
          ta <= t_rdata; va <= v_rdata;
          before_index <= 4'(bidx);
          after_index  <= 4'(aidx);
          factor <= '0;
          lane <= '0;
          if (bidx != aidx) begin
            state <= S_DIV;
          end else begin
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (ta > tb && rtreq >= tb) begin
            state <= S_WAITDIV;
          end else begin
            state <= S_MUL;
          end
        end
        S_WAITDIV: begin
          if (drsp.done) begin
            factor <= drsp.quot;
            state <= S_MUL;
          end
        end
        // One lane per S_MUL/S_BLEND pair: multiply, then add.
        S_MUL: begin
          blend_factor <= factor;
          prod <= diff * $signed({1'b0, factor});
          state <= S_BLEND;
        end
        S_BLEND: begin
          if ({1'b0, lane} < nc) begin
            case (lane)
              2'd0: result_0 <= a_sel + 16'(prod >>> 16);
              2'd1: result_1 <= a_sel + 16'(prod >>> 16);
              2'd2: result_2 <= a_sel + 16'(prod >>> 16);
              default: result_3 <= a_sel + 16'(prod >>> 16);
            endcase
          end
          lane <= lane + 2'd1;
          state <= (lane == 2'd3) ? S_OUT : S_MUL;
        end
        // Range walk over the table.
        S_RWALK: begin
          if (!rphase) begin
            rphase <= 1'b1;
          end else begin
            rphase <= 1'b0;
            if (!cnt_phase && t_rdata < rtreq) begin
              idx <= idx + 1'b1;
              if (idx + 1'b1 >= key_count) state <= S_OUT;
            end else if (t_rdata < rtend) begin
              cnt_phase <= 1'b1;
              cnt <= cnt + 5'd1;
              keys_in_range <= cnt + 5'd1;
              total <= total + ipart_t;
              range_total <= total + ipart_t;
              idx <= idx + 1'b1;
              if (idx + 1'b1 >= key_count) state <= S_OUT;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/kli_checker.sv -----
module kli_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [3:0] before_index,
  input logic [3:0] after_index
);

  // A held response stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("response changed while stalled");

  // No request is taken while a response waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken with response pending");

  // Never a request in flight without a later response blocking the input.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready directly after a request");

  // Status is never the unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status");

  // Before index never exceeds after index.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> before_index <= after_index)
    else $error("neighbour order broken");

endmodule

bind keyframe_linear_interpolator_unit kli_checker u_kli_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .before_index(before_index), .after_index(after_index)
);

// ----- verif/keyframe_linear_interpolator_unit_checker.sv -----
module keyframe_linear_interpolator_unit_checker
  import kli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [15:0]        time_req,
  input  logic [15:0]        time_end,
  input  logic signed [15:0] value_0,
  input  logic signed [15:0] value_1,
  input  logic signed [15:0] value_2,
  input  logic signed [15:0] value_3,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic signed [15:0] result_0,
  input  logic signed [15:0] result_1,
  input  logic signed [15:0] result_2,
  input  logic signed [15:0] result_3,
  input  logic [3:0]         before_index,
  input  logic [3:0]         after_index,
  input  logic [16:0]        blend_factor,
  input  logic [4:0]         keys_in_range,
  input  logic signed [11:0] range_total,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KeyDepth = 16;

  typedef struct packed {
    logic [1:0]       st;
    logic [3:0][15:0] res;
    logic [3:0]       lo_idx;
    logic [3:0]       hi_idx;
    logic [16:0]      weight;
    logic [4:0]       hits;
    logic [11:0]      sum;
  } answer_t;

  // Shadow copy of the key table and the component register.
  logic [15:0]      key_time [KeyDepth];
  logic [3:0][15:0] key_val  [KeyDepth];
  int               key_total;
  logic [2:0]       comp_reg;
  answer_t          awaited[$];

  assign pending = awaited.size();

  // Works out the answer to one request and updates the shadow table.
  function automatic answer_t interpolate(input logic [1:0] k, input logic [15:0] tq,
                                          input logic [15:0] te,
                                          input logic [3:0][15:0] vals);
    answer_t    a;
    int         i, lo, hi, nc;
    int         tlo, thi, acc;
    longint     w, va, vb, r;
    a = '0;
    case (k)
      KIND_CLEAR: key_total = 0;
      KIND_APPEND: begin
        if (key_total >= KeyDepth) begin
          a.st = ST_FULL;
        end else begin
          key_time[key_total] = tq;
          key_val[key_total]  = vals;
          key_total++;
        end
      end
      KIND_SAMPLE: begin
        if (key_total == 0) begin
          a.st = ST_EMPTY;
          return a;
        end
        i = 0;
        if (tq != 0) begin
          while (i < key_total && key_time[i] < tq) i++;
        end
        hi = (i < key_total) ? i : key_total - 1;
        lo = (i > 0) ? i - 1 : 0;
        if (lo > key_total - 1) lo = key_total - 1;
        w = 0;
        if (lo != hi) begin
          tlo = key_time[lo];
          thi = key_time[hi];
          if (thi > tlo && int'(tq) >= tlo) begin
            w = (longint'(int'(tq) - tlo) << 16) / longint'(thi - tlo);
            if (w > 65536) w = 65536;
          end
        end
        nc = comp_reg;
        if (nc < 1) nc = 1;
        if (nc > 4) nc = 4;
        for (int c = 0; c < nc; c++) begin
          va = longint'($signed(key_val[lo][c]));
          vb = longint'($signed(key_val[hi][c]));
          // Arithmetic shift gives the floor of the scaled difference.
          r = va + (((vb - va) * w) >>> 16);
          a.res[c] = r[15:0];
        end
        a.lo_idx = lo[3:0];
        a.hi_idx = hi[3:0];
        a.weight = w[16:0];
      end
      default: begin
        i = 0;
        acc = 0;
        lo = 0;
        while (i < key_total && key_time[i] < tq) i++;
        while (i < key_total && key_time[i] < te) begin
          acc += int'($signed(key_val[i][0])) / 256;
          lo++;
          i++;
        end
        a.hits = lo[4:0];
        a.sum  = acc[11:0];
      end
    endcase
    return a;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  // Predict on every accepted request, compare on every accepted response.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      key_total = 0;
      comp_reg  = 3'd1;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == {REG_COMPONENTS, 1'b0})
        comp_reg = pwdata[2:0];
      if (in_valid && in_ready)
        awaited.push_back(interpolate(kind, time_req, time_end,
                                      {value_3, value_2, value_1, value_0}));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: response with no request outstanding", $time);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          check_field("status", want.st, status);
          check_field("result_0", want.res[0], $unsigned(result_0));
          check_field("result_1", want.res[1], $unsigned(result_1));
          check_field("result_2", want.res[2], $unsigned(result_2));
          check_field("result_3", want.res[3], $unsigned(result_3));
          check_field("before_index", want.lo_idx, before_index);
          check_field("after_index", want.hi_idx, after_index);
          check_field("blend_factor", want.weight, blend_factor);
          check_field("keys_in_range", want.hits, keys_in_range);
          check_field("range_total", want.sum, $unsigned(range_total));
        end
      end
    end
  end

endmodule

// ----- verif/keyframe_linear_interpolator_unit_tb.sv -----
module keyframe_linear_interpolator_unit_tb;
  import kli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic [15:0]        time_req;
  logic [15:0]        time_end;
  logic signed [15:0] value_0;
  logic signed [15:0] value_1;
  logic signed [15:0] value_2;
  logic signed [15:0] value_3;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic signed [15:0] result_0;
  logic signed [15:0] result_1;
  logic signed [15:0] result_2;
  logic signed [15:0] result_3;
  logic [3:0]         before_index;
  logic [3:0]         after_index;
  logic [16:0]        blend_factor;
  logic [4:0]         keys_in_range;
  logic signed [11:0] range_total;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 burst_left;
  int                 sent;

  keyframe_linear_interpolator_unit DUT (.*);

  keyframe_linear_interpolator_unit_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Response side: a changing stall pattern, with one long hold-off once the
  // block is well into the run so that the input backs up.
  initial begin
    int taken;
    int mode;
    taken = 0;
    mode  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken == 60) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        taken++;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one request, with burst and gap pacing, and waits for it to be taken.
  task automatic send_request(input logic [1:0] k, input logic [15:0] tq,
                              input logic [15:0] te, input logic [15:0] v0,
                              input logic [15:0] v1, input logic [15:0] v2,
                              input logic [15:0] v3);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= k;
    time_req <= tq;
    time_end <= te;
    value_0  <= v0;
    value_1  <= v1;
    value_2  <= v2;
    value_3  <= v3;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_random_values(input logic [1:0] k, input logic [15:0] tq,
                                    input logic [15:0] te);
    send_request(k, tq, te, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Writes the component count once every response has come back.
  task automatic set_components(input logic [31:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_COMPONENTS, 1'b0};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // A well-formed sequence: clear, non-decreasing keys, then queries around them.
  task automatic keyed_sequence();
    int          n;
    int          t;
    int          step;
    logic [15:0] q;
    n    = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
    step = ($urandom_range(0, 1) == 1) ? 4000 : 300;
    t    = $urandom_range(0, 500);
    send_random_values(KIND_CLEAR, 16'($urandom), 16'($urandom));
    for (int j = 0; j < n; j++) begin
      send_random_values(KIND_APPEND, 16'(t), 16'($urandom));
      t += $urandom_range(0, step);
      if (t > 65535) t = 65535;
    end
    repeat ($urandom_range(2, 8)) begin
      q = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, t + 20));
      if ($urandom_range(0, 2) == 0)
        send_random_values(KIND_RANGE, q, 16'($urandom_range(0, t + 20)));
      else
        send_random_values(KIND_SAMPLE, q, 16'($urandom));
    end
  endtask

  initial begin
    logic [2:0] cfg_cycle [6] = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1};
    int         phase;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_CLEAR;
    time_req   <= '0;
    time_end   <= '0;
    value_0    <= '0;
    value_1    <= '0;
    value_2    <= '0;
    value_3    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    burst_left = 0;
    sent       = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty table, extreme keys, out-of-order key, edge queries.
    set_components(32'd4);
    send_random_values(KIND_SAMPLE, 16'd100, 16'd0);
    send_random_values(KIND_RANGE, 16'd0, 16'hFFFF);
    send_request(KIND_APPEND, 16'h0000, 16'd0, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_request(KIND_APPEND, 16'h0100, 16'd0, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCC);
    send_request(KIND_APPEND, 16'h8000, 16'd0, 16'hFF80, 16'h0180, 16'h8000, 16'h7FFF);
    send_random_values(KIND_APPEND, 16'hFFFF, 16'd0);
    send_random_values(KIND_APPEND, 16'h0080, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h0000, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h0080, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h0100, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h00C0, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h4000, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h8000, 16'd0);
    send_random_values(KIND_SAMPLE, 16'hFFFF, 16'd0);
    send_random_values(KIND_RANGE, 16'h0000, 16'hFFFF);
    send_random_values(KIND_RANGE, 16'h0100, 16'h8000);
    send_random_values(KIND_RANGE, 16'hFFFF, 16'h0000);
    send_random_values(KIND_RANGE, 16'h0080, 16'h0081);
    send_random_values(KIND_CLEAR, 16'd0, 16'd0);
    send_random_values(KIND_SAMPLE, 16'h0200, 16'd0);

    // Random part: mostly well-formed sequences, some raw noise, and a new
    // component count every so often.
    phase = 0;
    while (sent < 430) begin
      if (sent > 100 * (phase + 1)) begin
        set_components(32'(cfg_cycle[phase % 6]));
        phase++;
      end
      if ($urandom_range(0, 9) < 7)
        keyed_sequence();
      else
        repeat ($urandom_range(1, 6))
          send_random_values(2'($urandom), 16'($urandom), 16'($urandom));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
